### rtl/todc_pkg.sv
package todc_pkg;

    // Request codes
    localparam logic [3:0] REQ_TICK     = 4'd0;
    localparam logic [3:0] REQ_TAKE_EV  = 4'd1;
    localparam logic [3:0] REQ_SET_SEC  = 4'd2;
    localparam logic [3:0] REQ_SET_MIN  = 4'd3;
    localparam logic [3:0] REQ_SET_HOUR = 4'd4;
    localparam logic [3:0] REQ_INC_SEC  = 4'd5;
    localparam logic [3:0] REQ_INC_MIN  = 4'd6;
    localparam logic [3:0] REQ_INC_HOUR = 4'd7;
    localparam logic [3:0] REQ_CLR_DAYS = 4'd8;

    // Event flag bits
    localparam int EV_PORTION = 0;
    localparam int EV_SECOND  = 1;
    localparam int EV_MINUTE  = 2;
    localparam int EV_HOUR    = 3;
    localparam int EV_DAY     = 4;

    // Wrap limits and reset divider
    localparam logic [5:0] SEC_LIMIT   = 6'd60;
    localparam logic [5:0] MIN_LIMIT   = 6'd60;
    localparam logic [4:0] HOUR_LIMIT  = 5'd24;
    localparam logic [7:0] DIV_RESET   = 8'd3;

    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] set_value;
    } t_todc_req;

    typedef struct packed {
        logic [5:0]  seconds_now;
        logic [5:0]  minutes_now;
        logic [4:0]  hours_now;
        logic [15:0] day_count;
        logic [4:0]  taken_events;
    } t_todc_rsp;

    // Input stage to core: a held request and whether it moves on this cycle
    typedef struct packed {
        logic      fire;
        t_todc_req req;
    } t_todc_issue;

endpackage

### rtl/time_of_day_counter_with_events.sv
// A request is held in the input register and its result in the result register;
// a stall at the output holds the result, and then the request behind it.
// Throughput: one request per cycle; the input register and the result register
// each hold one request, so a waiting result stalls the input once the input
// register is full.
// Reset (synchronous, active low) clears the time, day count, prescaler and
// event flags, sets the tick divider to 3 and empties both registers.
module time_of_day_counter_with_events (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  todc_pkg::t_todc_req i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output todc_pkg::t_todc_rsp o_out_rsp
);
    import todc_pkg::*;

    t_todc_issue issue;
    t_todc_rsp   rsp;
    logic        can_pass;

    assign o_cfg_ready = 1'b1;

    todc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_can_pass (can_pass),
        .o_issue    (issue)
    );

    todc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_issue     (issue),
        .o_rsp       (rsp)
    );

    todc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (issue.fire),
        .i_rsp       (rsp),
        .o_can_pass  (can_pass),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

### rtl/todc_in_stage.sv
module todc_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  todc_pkg::t_todc_req i_in_req,
    input  logic               i_can_pass,
    output todc_pkg::t_todc_issue o_issue
);
    import todc_pkg::*;

    logic      r_vld;
    logic      n_vld;
    t_todc_req r_req;
    logic      fire;

    // Pass the held request on when the result side can take it
    assign fire       = r_vld && i_can_pass;
    assign o_in_ready = !r_vld || i_can_pass;

    always_comb begin
        n_vld = r_vld;
        if (fire) begin
            n_vld = 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in_req;
        end
    end

    assign o_issue.fire = fire;
    assign o_issue.req  = r_req;

endmodule

### rtl/todc_core.sv
module todc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [7:0]            i_cfg_data,
    input  todc_pkg::t_todc_issue i_issue,
    output todc_pkg::t_todc_rsp   o_rsp
);
    import todc_pkg::*;

    logic [7:0]  r_div;
    logic [7:0]  r_presc, n_presc;
    logic [5:0]  r_sec, n_sec;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_hour, n_hour;
    logic [15:0] r_day, n_day;
    logic [4:0]  r_ev, n_ev;
    logic [4:0]  taken;
    logic [5:0]  sec_inc;
    logic [5:0]  min_inc;
    logic [4:0]  hour_inc;

    // Wrapped increments
    assign sec_inc  = (r_sec  >= SEC_LIMIT - 6'd1)  ? 6'd0 : r_sec  + 6'd1;
    assign min_inc  = (r_min  >= MIN_LIMIT - 6'd1)  ? 6'd0 : r_min  + 6'd1;
    assign hour_inc = (r_hour >= HOUR_LIMIT - 5'd1) ? 5'd0 : r_hour + 5'd1;

    // Next time and flags for the request at hand
    always_comb begin
        n_presc = r_presc;
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_day   = r_day;
        n_ev    = r_ev;
        taken   = 5'd0;
        case (i_issue.req.req_type)
            REQ_TICK: begin
                n_ev[EV_PORTION] = 1'b1;
                if (r_presc < r_div) begin
                    n_presc = r_presc + 8'd1;
                end else begin
                    n_presc         = 8'd0;
                    n_ev[EV_SECOND] = 1'b1;
                    n_sec           = sec_inc;
                    if (sec_inc == 6'd0) begin
                        n_ev[EV_MINUTE] = 1'b1;
                        n_min           = min_inc;
                        if (min_inc == 6'd0) begin
                            n_ev[EV_HOUR] = 1'b1;
                            n_hour        = hour_inc;
                            if (hour_inc == 5'd0) begin
                                n_ev[EV_DAY] = 1'b1;
                                n_day        = r_day + 16'd1;
                            end
                        end
                    end
                end
            end
            REQ_TAKE_EV: begin
                taken = r_ev;
                n_ev  = 5'd0;
            end
            REQ_SET_SEC: begin
                if (i_issue.req.set_value < 8'(SEC_LIMIT)) begin
                    n_sec = i_issue.req.set_value[5:0];
                end
            end
            REQ_SET_MIN: begin
                if (i_issue.req.set_value < 8'(MIN_LIMIT)) begin
                    n_min = i_issue.req.set_value[5:0];
                end
            end
            REQ_SET_HOUR: begin
                if (i_issue.req.set_value < 8'(HOUR_LIMIT)) begin
                    n_hour = i_issue.req.set_value[4:0];
                end
            end
            REQ_INC_SEC:  n_sec  = sec_inc;
            REQ_INC_MIN:  n_min  = min_inc;
            REQ_INC_HOUR: n_hour = hour_inc;
            REQ_CLR_DAYS: n_day  = 16'd0;
            default: ;
        endcase
    end

    // Commit state when the request moves to the result register; load the divider whenever a config write is valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= DIV_RESET;
            r_presc <= 8'd0;
            r_sec   <= 6'd0;
            r_min   <= 6'd0;
            r_hour  <= 5'd0;
            r_day   <= 16'd0;
            r_ev    <= 5'd0;
        end else begin
            if (i_cfg_valid) begin
                r_div <= i_cfg_data;
            end
            if (i_issue.fire) begin
                r_presc <= n_presc;
                r_sec   <= n_sec;
                r_min   <= n_min;
                r_hour  <= n_hour;
                r_day   <= n_day;
                r_ev    <= n_ev;
            end
        end
    end

    assign o_rsp.seconds_now  = n_sec;
    assign o_rsp.minutes_now  = n_min;
    assign o_rsp.hours_now    = n_hour;
    assign o_rsp.day_count    = n_day;
    assign o_rsp.taken_events = taken;

endmodule

### rtl/todc_out_stage.sv
module todc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  todc_pkg::t_todc_rsp i_rsp,
    output logic                o_can_pass,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output todc_pkg::t_todc_rsp o_out_rsp
);
    import todc_pkg::*;

    logic      r_vld;
    logic      n_vld;
    t_todc_rsp r_rsp;

    // Room for a new result when empty or the current one leaves now
    assign o_can_pass = !r_vld || i_out_ready;

    always_comb begin
        n_vld = r_vld;
        if (r_vld && i_out_ready) begin
            n_vld = 1'b0;
        end
        if (i_fire) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Load the result
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_rsp   = r_rsp;

endmodule

### rtl/todc_chk.sv
module todc_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input todc_pkg::t_todc_rsp o_out_rsp
);
    import todc_pkg::*;

    // Drop any result during reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled result changed");

    // Expect a valid result once an accepted request has passed the input register and the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##2 o_out_valid)
        else $error("no result after accepted request");

    // Keep the shown time in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_rsp.seconds_now < SEC_LIMIT
                     && o_out_rsp.minutes_now < MIN_LIMIT
                     && o_out_rsp.hours_now < HOUR_LIMIT)
        else $error("time out of range");

    // When the second flag is set, each carry flag implies the flags below it
    a_ev_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.taken_events[EV_SECOND]
        |-> o_out_rsp.taken_events[EV_PORTION]
            && (!o_out_rsp.taken_events[EV_DAY] || o_out_rsp.taken_events[EV_HOUR])
            && (!o_out_rsp.taken_events[EV_HOUR] || o_out_rsp.taken_events[EV_MINUTE])
            && (!o_out_rsp.taken_events[EV_MINUTE] || o_out_rsp.taken_events[EV_SECOND]))
        else $error("event flags inconsistent");

endmodule

bind time_of_day_counter_with_events todc_chk u_chk (.*);
